/* hw/rtl/refresh_rate_lag_slewer_assert.svh */
// Assertion macros for the refresh rate lag slewer.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef REFRESH_RATE_LAG_SLEWER_ASSERT_SVH
`define REFRESH_RATE_LAG_SLEWER_ASSERT_SVH

`ifndef SYNTHESIS

`define RRLS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rrls: same-cycle check failed");

`define RRLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rrls: next-cycle check failed");

`else

`define RRLS_ASSERT_SAME(lbl, ante, cons)
`define RRLS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hw/rtl/rrls_pkg.sv */
package rrls_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  typedef enum logic [1:0] {
    ACT_UPDATE     = 2'd0,
    ACT_QUERY      = 2'd1,
    ACT_INVALIDATE = 2'd2,
    ACT_NOP        = 2'd3
  } act_e;

  typedef enum logic {
    CFG_MIN_PERIOD = 1'b0,
    CFG_MAX_PERIOD = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_EXEC = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/refresh_rate_lag_slewer.sv */
// Refresh period and lag slewer.
// Input channel (in_valid_i/in_ready_o) carries one transaction per item: an
// action code, a reported period and a reported lag. Every item yields exactly
// one result transaction on the output channel (out_valid_o/out_ready_i).
// The configuration channel writes min_period (index 0) or max_period
// (index 1); it is always ready and must only be used while the block is idle.
// An update with a nonzero period below min_period runs a bit-serial divider,
// one quotient bit per step over all 16 bits, then a multiply step, before its
// result is written; all other items go straight to the write. A new item is
// taken only once the current one's result has been written, and the next item
// can be taken as soon as that result appears.
// Results sit in an output register; the next item is accepted and processed
// while that register still waits, and only the final write stalls until the
// receiver drains it. Reset sets min_period to 1750, max_period to 50000 and
// clears the stored period, the pending lag and the output valid flag.
`include "refresh_rate_lag_slewer_assert.svh"

module refresh_rate_lag_slewer
  import rrls_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic        [15:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [1:0]  action_i,
  input  logic        [15:0] new_period_i,
  input  logic signed [15:0] new_lag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [15:0] period_out_o,
  output logic signed [15:0] lag_left_o,
  output logic               accepted_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  rrls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrls_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .action_i     (action_i),
    .new_period_i (new_period_i),
    .new_lag_i    (new_lag_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .period_out_o (period_out_o),
    .lag_left_o   (lag_left_o),
    .accepted_o   (accepted_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  // A result is never written over one that the receiver has not taken.
  `RRLS_ASSERT_SAME(a_exec_no_overwrite, cmd.exec, !out_valid_o || out_ready_i)
  // Writing a result always presents it in the next cycle.
  `RRLS_ASSERT_NEXT(a_exec_shows_result, cmd.exec, out_valid_o)
  // After an accepted transaction the block is busy in the next cycle.
  `RRLS_ASSERT_NEXT(a_accept_goes_busy, in_valid_i && in_ready_o, !in_ready_o)

endmodule

/* hw/rtl/rrls_ctrl.sv */
module rrls_ctrl
  import rrls_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.need_div ? ST_DIV : ST_EXEC;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_EXEC;
      end
      ST_EXEC: begin
        // The result register must be empty or draining before it is reloaded.
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

/* hw/rtl/rrls_dp.sv */
module rrls_dp
  import rrls_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_index_i,
  input  logic        [DataW-1:0] cfg_data_i,
  input  logic        [1:0]       action_i,
  input  logic        [DataW-1:0] new_period_i,
  input  logic signed [DataW-1:0] new_lag_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic        [DataW-1:0] period_out_o,
  output logic signed [DataW-1:0] lag_left_o,
  output logic                    accepted_o,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o
);

  logic [DataW-1:0] min_q, max_q;
  logic [DataW-1:0] stored_q, lag_q;
  logic             out_valid_q;

  act_e             act_q;
  logic [DataW-1:0] np_q, nl_q, div_q, rem_q, quo_q, prod_q;

  logic [DataW:0]     np_inc, shifted, diff;
  logic               ge;
  logic [2*DataW-1:0] prod_full;

  logic [DataW-1:0] cond_period, period_nxt, stored_nxt, lag_nxt;
  logic             acc_nxt;
  logic signed [DataW+1:0] sum, lo_ext, hi_ext;
  logic [DataW-1:0] adj;

  assign sts_o.need_div = (act_e'(action_i) == ACT_UPDATE) && (new_period_i != '0)
                          && (new_period_i < min_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign np_inc    = {1'b0, new_period_i} + (DataW+1)'(1);
  assign shifted   = {rem_q, quo_q[DataW-1]};
  assign ge        = shifted >= {1'b0, div_q};
  assign diff      = shifted - {1'b0, div_q};
  assign prod_full = np_q * quo_q;

  // Restoring division of min_period by (rate + 1), one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= act_e'(action_i);
      np_q  <= new_period_i;
      nl_q  <= new_lag_i;
      div_q <= np_inc[DataW-1:0];
      rem_q <= '0;
      quo_q <= min_q;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[DataW-1:0] : shifted[DataW-1:0];
      quo_q <= {quo_q[DataW-2:0], ge};
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full[DataW-1:0];
    end
  end

  always_comb begin
    if (np_q < min_q) begin
      cond_period = prod_q;
    end else if (np_q > max_q) begin
      cond_period = max_q;
    end else begin
      cond_period = np_q;
    end
  end

  assign sum    = $signed({2'b00, stored_q}) + $signed({{2{lag_q[DataW-1]}}, lag_q});
  assign lo_ext = $signed({2'b00, min_q});
  assign hi_ext = $signed({2'b00, max_q});

  always_comb begin
    if (sum < lo_ext) begin
      adj = min_q;
    end else if (sum > hi_ext) begin
      adj = max_q;
    end else begin
      adj = sum[DataW-1:0];
    end
  end

  always_comb begin
    stored_nxt = stored_q;
    lag_nxt    = lag_q;
    period_nxt = stored_q;
    acc_nxt    = 1'b0;
    unique case (act_q)
      ACT_UPDATE: begin
        if (np_q != '0) begin
          stored_nxt = cond_period;
          lag_nxt    = nl_q;
          period_nxt = cond_period;
          acc_nxt    = 1'b1;
        end
      end
      ACT_QUERY: begin
        if (lag_q != '0) begin
          period_nxt = adj;
          // Remove the applied change from the pending lag, wrapping at 16 bits.
          lag_nxt    = lag_q - adj + stored_q;
        end
      end
      ACT_INVALIDATE: begin
        lag_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= DataW'(1750);
      max_q       <= DataW'(50000);
      stored_q    <= '0;
      lag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_MIN_PERIOD: min_q <= cfg_data_i;
          CFG_MAX_PERIOD: max_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.exec) begin
        stored_q    <= stored_nxt;
        lag_q       <= lag_nxt;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      period_out_o <= period_nxt;
      lag_left_o   <= lag_nxt;
      accepted_o   <= acc_nxt;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* tb/rrls_period_checker.sv */
module rrls_period_checker
  import rrls_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_index_i,
  input  logic        [15:0] cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic        [1:0]  action_i,
  input  logic        [15:0] new_period_i,
  input  logic signed [15:0] new_lag_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic        [15:0] period_out_i,
  input  logic signed [15:0] lag_left_i,
  input  logic               accepted_i,
  output int                 mismatch_count_o,
  output int                 waiting_count_o,
  output int                 results_seen_o
);

  typedef struct packed {
    logic        [15:0] period;
    logic signed [15:0] lag;
    logic               accepted;
  } slew_result_t;

  logic        [15:0] min_period_q;
  logic        [15:0] max_period_q;
  logic        [15:0] stored_period_q;
  logic signed [15:0] pending_lag_q;
  slew_result_t       predicted_outputs_q[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count_o++;
    if (mismatch_count_o <= 40) begin
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  // A short period is scaled up by the integer ratio min / (period + 1).
  function automatic logic [15:0] conditioned_period(input logic [15:0] rate);
    int unsigned rate32;
    int unsigned lo32;
    int unsigned prod;
    rate32 = rate;
    lo32   = min_period_q;
    if (rate32 < lo32) begin
      prod = rate32 * (lo32 / (rate32 + 1));
      return 16'(prod);
    end
    if (rate < max_period_q) return rate;
    if (rate > max_period_q) return max_period_q;
    return rate;
  endfunction

  function automatic slew_result_t apply_slewer_item(input act_e act,
                                                     input logic [15:0] rate,
                                                     input logic signed [15:0] lag);
    slew_result_t res;
    int           base;
    int           adj;
    int           lag32;
    res.accepted = 1'b0;
    res.period   = stored_period_q;
    case (act)
      ACT_UPDATE: begin
        if (rate != 16'd0) begin
          stored_period_q = conditioned_period(rate);
          pending_lag_q   = lag;
          res.accepted    = 1'b1;
        end
        res.period = stored_period_q;
      end
      ACT_QUERY: begin
        lag32 = pending_lag_q;
        base  = int'(stored_period_q);
        if (lag32 != 0) begin
          adj = base + lag32;
          // The lower limit is tested first, which matters when min > max.
          if (adj < int'(min_period_q)) adj = int'(min_period_q);
          else if (adj > int'(max_period_q)) adj = int'(max_period_q);
          pending_lag_q = pending_lag_q - 16'(adj - base);
          res.period    = 16'(adj);
        end
      end
      ACT_INVALIDATE: begin
        pending_lag_q = 16'sd0;
      end
      default: begin
      end
    endcase
    res.lag = pending_lag_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    slew_result_t want;
    if (!rst_ni) begin
      min_period_q     = 16'd1750;
      max_period_q     = 16'd50000;
      stored_period_q  = 16'd0;
      pending_lag_q    = 16'sd0;
      mismatch_count_o = 0;
      results_seen_o   = 0;
      predicted_outputs_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MIN_PERIOD: min_period_q = cfg_data_i;
          CFG_MAX_PERIOD: max_period_q = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        results_seen_o++;
        if (predicted_outputs_q.size() == 0) begin
          report_mismatch("result transaction with nothing pending, period_out",
                          period_out_i, -1);
        end else begin
          want = predicted_outputs_q.pop_front();
          if (period_out_i !== want.period)
            report_mismatch("period_out", period_out_i, want.period);
          if (lag_left_i !== want.lag)
            report_mismatch("lag_left", lag_left_i, want.lag);
          if (accepted_i !== want.accepted)
            report_mismatch("accepted", accepted_i, want.accepted);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted_outputs_q.push_back(
          apply_slewer_item(act_e'(action_i), new_period_i, new_lag_i));
      end
    end
    waiting_count_o = predicted_outputs_q.size();
  end

endmodule

/* tb/tb.sv */
module tb;
  import rrls_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_MIN_PERIOD;
  logic        [15:0] cfg_data = 16'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic        [1:0]  action = ACT_NOP;
  logic        [15:0] new_period = 16'd0;
  logic signed [15:0] new_lag = 16'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic        [15:0] period_out;
  logic signed [15:0] lag_left;
  logic               accepted;

  int mismatches;
  int waiting;
  int results_seen;
  int item_count = 0;
  int setting_count = 1;
  int cur_min = 1750;
  int cur_max = 50000;
  int hold_request = 0;
  bit idle_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  refresh_rate_lag_slewer DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (action),
    .new_period_i (new_period),
    .new_lag_i    (new_lag),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .period_out_o (period_out),
    .lag_left_o   (lag_left),
    .accepted_o   (accepted)
  );

  rrls_period_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .action_i         (action),
    .new_period_i     (new_period),
    .new_lag_i        (new_lag),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .period_out_i     (period_out),
    .lag_left_i       (lag_left),
    .accepted_i       (accepted),
    .mismatch_count_o (mismatches),
    .waiting_count_o  (waiting),
    .results_seen_o   (results_seen)
  );

  task automatic send_item(input act_e act, input logic [15:0] rate, input logic [15:0] lag);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    new_period <= rate;
    new_lag    <= lag;
    do @(posedge clk); while (!in_ready);
    item_count++;
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_limits(input int lo, input int hi);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MIN_PERIOD;
    cfg_data  <= 16'(lo);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_MAX_PERIOD;
    cfg_data  <= 16'(hi);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_min = lo;
    cur_max = hi;
    setting_count++;
  endtask

  task automatic random_item();
    int          r;
    logic [15:0] rate;
    logic [15:0] lag;
    act_e        act;
    r    = $urandom_range(0, 99);
    act  = act_e'(r < 40 ? ACT_UPDATE : r < 75 ? ACT_QUERY : r < 88 ? ACT_INVALIDATE : ACT_NOP);
    rate = 16'($urandom);
    lag  = 16'($urandom);
    if (act == ACT_UPDATE) begin
      r = $urandom_range(0, 99);
      if (r < 8) rate = 16'd0;
      else if (r < 40 && cur_min > 1) rate = 16'($urandom_range(1, cur_min - 1));
      else if (r < 70 && cur_min <= cur_max) rate = 16'($urandom_range(cur_min, cur_max));
      else if (r < 85 && cur_max < 65535) rate = 16'($urandom_range(cur_max + 1, 65535));
      r = $urandom_range(0, 9);
      if (r < 4) begin
        lag = 16'($urandom_range(0, 600) - 300);
      end else if (r < 6) begin
        case ($urandom_range(0, 4))
          0: lag = 16'h8000;
          1: lag = 16'h7fff;
          2: lag = 16'hffff;
          3: lag = 16'h0001;
          default: lag = 16'h0000;
        endcase
      end
    end
    send_item(act, rate, lag);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) idle_on = ($urandom_range(0, 3) != 0);
      random_item();
    end
  endtask

  // Receiver: a fresh stall per result transaction, or a long hold-off on request.
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else begin
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #2000000;
    $display("FAIL refresh_rate_lag_slewer");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset limits.
    send_item(ACT_QUERY, 16'd0, 16'd0);
    send_item(ACT_UPDATE, 16'd0, 16'h7fff);
    send_item(ACT_UPDATE, 16'd1, 16'h0000);
    send_item(ACT_QUERY, 16'hffff, 16'hffff);
    send_item(ACT_UPDATE, 16'd1749, 16'h0000);
    send_item(ACT_UPDATE, 16'd1750, 16'h7fff);
    send_item(ACT_QUERY, 16'd0, 16'd0);
    send_item(ACT_UPDATE, 16'hffff, 16'h8000);
    send_item(ACT_QUERY, 16'd0, 16'd0);
    send_item(ACT_UPDATE, 16'd50001, 16'h0001);
    send_item(ACT_QUERY, 16'd0, 16'd0);
    send_item(ACT_QUERY, 16'd0, 16'd0);
    send_item(ACT_INVALIDATE, 16'hffff, 16'hffff);
    send_item(ACT_QUERY, 16'd0, 16'd0);
    send_item(ACT_UPDATE, 16'd100, 16'h8000);
    send_item(ACT_QUERY, 16'd0, 16'd0);
    send_item(ACT_QUERY, 16'd0, 16'd0);
    send_item(ACT_NOP, 16'hffff, 16'hffff);
    send_item(ACT_UPDATE, 16'd50000, 16'hffff);
    send_item(ACT_QUERY, 16'd0, 16'd0);
    send_item(ACT_INVALIDATE, 16'd0, 16'd0);

    run_random(70);

    // The receiver stops long enough for the block to back up its input.
    idle_on      = 1'b0;
    hold_request = 60;
    repeat (25) random_item();
    drain_results();
    run_random(40);

    set_limits(1, 65535);
    run_random(60);
    set_limits(65535, 65535);
    run_random(40);
    set_limits(40000, 1000);
    run_random(50);
    set_limits(1, 1);
    run_random(40);
    repeat (2) begin
      set_limits($urandom_range(1, 65535), $urandom_range(1, 65535));
      run_random(50);
    end

    drain_results();
    repeat (25) @(posedge clk);
    @(negedge clk);
    $display("Checked %0d results from %0d items over %0d limit settings,", results_seen,
             item_count, setting_count);
    $display("including a receiver hold-off with a full pipeline and drained pauses.");
    if (mismatches == 0) begin
      $display("PASS refresh_rate_lag_slewer");
    end else begin
      $display("FAIL refresh_rate_lag_slewer");
    end
    $finish;
  end

endmodule
